### src/lfps_pkg.sv
`default_nettype none

package lfps_pkg;

   // fixed field widths
   localparam int SAMPLE_W    = 10;
   localparam int GAIN_W      = 16;
   localparam int PWM_W       = 8;
   localparam int ERR_W       = 5;
   localparam int DIFF_W      = 6;
   localparam int PID_W       = 16;
   localparam int LANE_MAX    = 8;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // default parameter values
   localparam int SENSOR_COUNT_DEF  = 8;
   localparam int INTEGRAL_BITS_DEF = 24;

   // drive decision limits on the steering error magnitude
   localparam logic signed [ERR_W-1:0] STRAIGHT_LIMIT = 5'sd4;
   localparam logic signed [ERR_W-1:0] HOLD_LIMIT     = 5'sd6;

   // per channel steering weights, leftmost first
   localparam logic signed [ERR_W-1:0] LANE_WEIGHT [LANE_MAX] = '{
      -5'sd5, -5'sd4, -5'sd3, 5'sd1, 5'sd1, 5'sd3, 5'sd4, 5'sd5
   };

   // register reset values
   localparam logic [GAIN_W-1:0]   GAIN_P_RST         = 16'd1536;
   localparam logic [GAIN_W-1:0]   GAIN_I_RST         = 16'd179;
   localparam logic [GAIN_W-1:0]   GAIN_D_RST         = 16'd282;
   localparam logic [SAMPLE_W-1:0] BLACK_LEVEL_RST    = 10'd800;
   localparam logic [SAMPLE_W-1:0] WHITE_LEVEL_RST    = 10'd750;
   localparam logic [PWM_W-1:0]    BASE_SPEED_RST     = 8'd200;
   localparam logic [PWM_W-1:0]    STRAIGHT_LEFT_RST  = 8'd255;
   localparam logic [PWM_W-1:0]    STRAIGHT_RIGHT_RST = 8'd243;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_P         = 4'd0,
      CSR_GAIN_I         = 4'd1,
      CSR_GAIN_D         = 4'd2,
      CSR_BLACK_LEVEL    = 4'd3,
      CSR_WHITE_LEVEL    = 4'd4,
      CSR_BASE_SPEED     = 4'd5,
      CSR_STRAIGHT_LEFT  = 4'd6,
      CSR_STRAIGHT_RIGHT = 4'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      DRV_STOP     = 3'd0,
      DRV_STRAIGHT = 3'd1,
      DRV_RIGHT    = 3'd2,
      DRV_LEFT     = 3'd3,
      DRV_HOLD     = 3'd4
   } drive_case_type;

   // what the pid pipeline hands to the drive stage
   typedef struct packed {
      logic                     valid;
      logic signed [ERR_W-1:0]  err;
      logic [LANE_MAX-1:0]      mask;
      logic signed [PID_W-1:0]  pid;
   } stage_type;

endpackage

`default_nettype wire

### src/line_follow_pid_steering_core.sv
`default_nettype none

// Line follower steering core. Each transaction on req_ carries one frame of eight
// 10-bit reflectance samples; one result per frame leaves on rsp_ with the left and
// right PWM speeds, the steering error, the PID output, the black channel mask and
// the drive case. One lane per channel classifies its sample with hysteresis, a
// merge stage sums the lane weights, and a pipelined PID (integral update, three
// gain multipliers, accumulate, scale and saturate) feeds the drive decision. A new
// frame is taken every cycle unless the pipeline stalls; its result passes register s1,
// the PID stages s2 to s5 and the drive output register before it is offered on rsp_,
// and the whole pipeline stalls only while a finished result waits on rsp_ready.
// Registers at csr_ indexes 0..7 (gain_p, gain_i, gain_d, black_level, white_level,
// base_speed, straight_left, straight_right) are written by the user only while the
// core is idle, which the core itself does not enforce; other indexes are ignored.
module line_follow_pid_steering_core #(
   parameter int SENSOR_COUNT  = lfps_pkg::SENSOR_COUNT_DEF,
   parameter int INTEGRAL_BITS = lfps_pkg::INTEGRAL_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [lfps_pkg::SAMPLE_W-1:0]       req_line_sensor_0,
   input  wire logic [lfps_pkg::SAMPLE_W-1:0]       req_line_sensor_1,
   input  wire logic [lfps_pkg::SAMPLE_W-1:0]       req_line_sensor_2,
   input  wire logic [lfps_pkg::SAMPLE_W-1:0]       req_line_sensor_3,
   input  wire logic [lfps_pkg::SAMPLE_W-1:0]       req_line_sensor_4,
   input  wire logic [lfps_pkg::SAMPLE_W-1:0]       req_line_sensor_5,
   input  wire logic [lfps_pkg::SAMPLE_W-1:0]       req_line_sensor_6,
   input  wire logic [lfps_pkg::SAMPLE_W-1:0]       req_line_sensor_7,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [lfps_pkg::PWM_W-1:0]               rsp_left_speed,
   output logic [lfps_pkg::PWM_W-1:0]               rsp_right_speed,
   output logic signed [lfps_pkg::ERR_W-1:0]        rsp_steer_error,
   output logic signed [lfps_pkg::PID_W-1:0]        rsp_pid_value,
   output logic [lfps_pkg::LANE_MAX-1:0]            rsp_black_mask,
   output logic [2:0]                               rsp_drive_case,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lfps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [lfps_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import lfps_pkg::*;

   logic                    adv;
   logic                    take;
   logic [SAMPLE_W-1:0]     sample [LANE_MAX];
   logic [LANE_MAX-1:0]     lane_black;
   logic signed [ERR_W-1:0] lane_weight [LANE_MAX];
   logic signed [ERR_W-1:0] err_in;
   logic                    s1_valid_ff;
   logic signed [ERR_W-1:0] s1_err_ff;
   logic [LANE_MAX-1:0]     s1_mask_ff;
   stage_type               pid_stage;

   logic [GAIN_W-1:0]       gain_p_ff;
   logic [GAIN_W-1:0]       gain_i_ff;
   logic [GAIN_W-1:0]       gain_d_ff;
   logic [SAMPLE_W-1:0]     black_level_ff;
   logic [SAMPLE_W-1:0]     white_level_ff;
   logic [PWM_W-1:0]        base_speed_ff;
   logic [PWM_W-1:0]        straight_left_ff;
   logic [PWM_W-1:0]        straight_right_ff;

   // whole pipeline moves unless a result is stuck at the output
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign take      = req_valid && adv;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff         <= GAIN_P_RST;
         gain_i_ff         <= GAIN_I_RST;
         gain_d_ff         <= GAIN_D_RST;
         black_level_ff    <= BLACK_LEVEL_RST;
         white_level_ff    <= WHITE_LEVEL_RST;
         base_speed_ff     <= BASE_SPEED_RST;
         straight_left_ff  <= STRAIGHT_LEFT_RST;
         straight_right_ff <= STRAIGHT_RIGHT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GAIN_P:         gain_p_ff         <= csr_wdata;
            CSR_GAIN_I:         gain_i_ff         <= csr_wdata;
            CSR_GAIN_D:         gain_d_ff         <= csr_wdata;
            CSR_BLACK_LEVEL:    black_level_ff    <= csr_wdata[SAMPLE_W-1:0];
            CSR_WHITE_LEVEL:    white_level_ff    <= csr_wdata[SAMPLE_W-1:0];
            CSR_BASE_SPEED:     base_speed_ff     <= csr_wdata[PWM_W-1:0];
            CSR_STRAIGHT_LEFT:  straight_left_ff  <= csr_wdata[PWM_W-1:0];
            CSR_STRAIGHT_RIGHT: straight_right_ff <= csr_wdata[PWM_W-1:0];
            default: ;
         endcase
      end
   end

   assign sample[0] = req_line_sensor_0;
   assign sample[1] = req_line_sensor_1;
   assign sample[2] = req_line_sensor_2;
   assign sample[3] = req_line_sensor_3;
   assign sample[4] = req_line_sensor_4;
   assign sample[5] = req_line_sensor_5;
   assign sample[6] = req_line_sensor_6;
   assign sample[7] = req_line_sensor_7;

   // one classification lane per active channel
   for (genvar g = 0; g < LANE_MAX; g++) begin : g_lane
      if (g < SENSOR_COUNT) begin : g_active
         lfps_lane #(
            .LANE_INDEX (g)
         ) u_lane (
            .clock       (clock),
            .reset       (reset),
            .take        (take),
            .sample      (sample[g]),
            .black_level (black_level_ff),
            .white_level (white_level_ff),
            .black       (lane_black[g]),
            .weight      (lane_weight[g])
         );
      end else begin : g_unused
         assign lane_black[g]  = 1'b0;
         assign lane_weight[g] = '0;
      end
   end

   // merge the lane weights into the steering error
   always_comb begin
      err_in = '0;
      for (int i = 0; i < LANE_MAX; i++) begin
         err_in = err_in + lane_weight[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_err_ff  <= err_in;
         s1_mask_ff <= lane_black;
      end
   end

   lfps_pid #(
      .INTEGRAL_BITS (INTEGRAL_BITS)
   ) u_pid (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (s1_valid_ff),
      .in_err   (s1_err_ff),
      .in_mask  (s1_mask_ff),
      .gain_p   (gain_p_ff),
      .gain_i   (gain_i_ff),
      .gain_d   (gain_d_ff),
      .result   (pid_stage)
   );

   lfps_drive u_drive (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .stage          (pid_stage),
      .base_speed     (base_speed_ff),
      .straight_left  (straight_left_ff),
      .straight_right (straight_right_ff),
      .out_valid      (rsp_valid),
      .left_speed     (rsp_left_speed),
      .right_speed    (rsp_right_speed),
      .steer_error    (rsp_steer_error),
      .pid_value      (rsp_pid_value),
      .black_mask     (rsp_black_mask),
      .drive_case     (rsp_drive_case)
   );

endmodule

`default_nettype wire

### src/lfps_lane.sv
`default_nettype none

module lfps_lane #(
   parameter int LANE_INDEX = 0
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             take,
   input  wire logic [lfps_pkg::SAMPLE_W-1:0]    sample,
   input  wire logic [lfps_pkg::SAMPLE_W-1:0]    black_level,
   input  wire logic [lfps_pkg::SAMPLE_W-1:0]    white_level,
   output logic                                  black,
   output logic signed [lfps_pkg::ERR_W-1:0]     weight
);
   import lfps_pkg::*;

   logic black_ff;

   // hysteresis classification, black test wins when thresholds cross
   always_comb begin
      if (sample >= black_level) begin
         black = 1'b1;
      end else if (sample <= white_level) begin
         black = 1'b0;
      end else begin
         black = black_ff;
      end
   end

   assign weight = black ? LANE_WEIGHT[3'(LANE_INDEX)] : '0;

   // channel state advances with every accepted frame
   always_ff @(posedge clock) begin
      if (reset) begin
         black_ff <= 1'b0;
      end else if (take) begin
         black_ff <= black;
      end
   end

endmodule

`default_nettype wire

### src/lfps_pid.sv
`default_nettype none

module lfps_pid #(
   parameter int INTEGRAL_BITS = lfps_pkg::INTEGRAL_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             adv,
   input  wire logic                             in_valid,
   input  wire logic signed [lfps_pkg::ERR_W-1:0] in_err,
   input  wire logic [lfps_pkg::LANE_MAX-1:0]    in_mask,
   input  wire logic [lfps_pkg::GAIN_W-1:0]      gain_p,
   input  wire logic [lfps_pkg::GAIN_W-1:0]      gain_i,
   input  wire logic [lfps_pkg::GAIN_W-1:0]      gain_d,
   output lfps_pkg::stage_type                   result
);
   import lfps_pkg::*;

   localparam int IB   = INTEGRAL_BITS;
   localparam int PPW  = GAIN_W + 1 + ERR_W;
   localparam int PIW  = GAIN_W + 1 + IB;
   localparam int PDW  = GAIN_W + 1 + DIFF_W;
   localparam int AW   = PIW + 2;
   localparam int QW   = AW - 8;

   // loop state
   logic signed [IB-1:0]     integ_ff;
   logic signed [ERR_W-1:0]  last_err_ff;

   // integral update stage
   logic signed [IB:0]       integ_sum;
   logic signed [IB-1:0]     integ_in;
   logic signed [DIFF_W-1:0] diff_in;
   logic                     s2_valid_ff;
   logic signed [ERR_W-1:0]  s2_err_ff;
   logic [LANE_MAX-1:0]      s2_mask_ff;
   logic signed [IB-1:0]     s2_integ_ff;
   logic signed [DIFF_W-1:0] s2_diff_ff;

   // product stage
   logic signed [PPW-1:0]    prod_p_in;
   logic signed [PIW-1:0]    prod_i_in;
   logic signed [PDW-1:0]    prod_d_in;
   logic                     s3_valid_ff;
   logic signed [ERR_W-1:0]  s3_err_ff;
   logic [LANE_MAX-1:0]      s3_mask_ff;
   logic signed [PPW-1:0]    s3_prod_p_ff;
   logic signed [PIW-1:0]    s3_prod_i_ff;
   logic signed [PDW-1:0]    s3_prod_d_ff;

   // accumulate stage
   logic signed [AW-1:0]     acc_in;
   logic                     s4_valid_ff;
   logic signed [ERR_W-1:0]  s4_err_ff;
   logic [LANE_MAX-1:0]      s4_mask_ff;
   logic signed [AW-1:0]     s4_acc_ff;

   // scale and saturate stage
   logic signed [QW-1:0]     quot;
   logic signed [QW-1:0]     quot_tz;
   logic signed [PID_W-1:0]  pid_in;
   logic                     s5_valid_ff;
   logic signed [ERR_W-1:0]  s5_err_ff;
   logic [LANE_MAX-1:0]      s5_mask_ff;
   logic signed [PID_W-1:0]  s5_pid_ff;

   // saturating integral and derivative
   assign integ_sum = (IB+1)'(integ_ff) + (IB+1)'(in_err);
   always_comb begin
      if (integ_sum[IB] != integ_sum[IB-1]) begin
         integ_in = integ_sum[IB] ? {1'b1, {(IB-1){1'b0}}} : {1'b0, {(IB-1){1'b1}}};
      end else begin
         integ_in = integ_sum[IB-1:0];
      end
   end
   assign diff_in = DIFF_W'(in_err) - DIFF_W'(last_err_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         last_err_ff <= '0;
      end else if (adv && in_valid) begin
         integ_ff    <= integ_in;
         last_err_ff <= in_err;
      end
   end

   // gain products, one multiplier per term
   assign prod_p_in = $signed({1'b0, gain_p}) * s2_err_ff;
   assign prod_i_in = $signed({1'b0, gain_i}) * s2_integ_ff;
   assign prod_d_in = $signed({1'b0, gain_d}) * s2_diff_ff;

   assign acc_in = AW'(s3_prod_p_ff) + AW'(s3_prod_i_ff) + AW'(s3_prod_d_ff);

   // divide by 256 rounding toward zero, then saturate
   assign quot    = QW'(s4_acc_ff >>> 8);
   assign quot_tz = quot + QW'(s4_acc_ff[AW-1] && (|s4_acc_ff[7:0]));
   always_comb begin
      if ((quot_tz[QW-1:PID_W-1] == '0) || (quot_tz[QW-1:PID_W-1] == '1)) begin
         pid_in = quot_tz[PID_W-1:0];
      end else if (quot_tz[QW-1]) begin
         pid_in = {1'b1, {(PID_W-1){1'b0}}};
      end else begin
         pid_in = {1'b0, {(PID_W-1){1'b1}}};
      end
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= in_valid;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_err_ff    <= in_err;
         s2_mask_ff   <= in_mask;
         s2_integ_ff  <= integ_in;
         s2_diff_ff   <= diff_in;
         s3_err_ff    <= s2_err_ff;
         s3_mask_ff   <= s2_mask_ff;
         s3_prod_p_ff <= prod_p_in;
         s3_prod_i_ff <= prod_i_in;
         s3_prod_d_ff <= prod_d_in;
         s4_err_ff    <= s3_err_ff;
         s4_mask_ff   <= s3_mask_ff;
         s4_acc_ff    <= acc_in;
         s5_err_ff    <= s4_err_ff;
         s5_mask_ff   <= s4_mask_ff;
         s5_pid_ff    <= pid_in;
      end
   end

   assign result.valid = s5_valid_ff;
   assign result.err   = s5_err_ff;
   assign result.mask  = s5_mask_ff;
   assign result.pid   = s5_pid_ff;

endmodule

`default_nettype wire

### src/lfps_drive.sv
`default_nettype none

module lfps_drive (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              adv,
   input  wire lfps_pkg::stage_type               stage,
   input  wire logic [lfps_pkg::PWM_W-1:0]        base_speed,
   input  wire logic [lfps_pkg::PWM_W-1:0]        straight_left,
   input  wire logic [lfps_pkg::PWM_W-1:0]        straight_right,
   output logic                                   out_valid,
   output logic [lfps_pkg::PWM_W-1:0]             left_speed,
   output logic [lfps_pkg::PWM_W-1:0]             right_speed,
   output logic signed [lfps_pkg::ERR_W-1:0]      steer_error,
   output logic signed [lfps_pkg::PID_W-1:0]      pid_value,
   output logic [lfps_pkg::LANE_MAX-1:0]          black_mask,
   output logic [2:0]                             drive_case
);
   import lfps_pkg::*;

   localparam int SW = PID_W + 2;

   function automatic logic [PWM_W-1:0] clamp_pwm(input logic signed [SW-1:0] v);
      logic [PWM_W-1:0] r;
      if (v[SW-1]) begin
         r = '0;
      end else if (v[SW-2:PWM_W] != '0) begin
         r = '1;
      end else begin
         r = v[PWM_W-1:0];
      end
      return r;
   endfunction

   logic signed [SW-1:0]    base_ext;
   logic [PWM_W-1:0]        plus_pwm;
   logic [PWM_W-1:0]        minus_pwm;
   drive_case_type          case_in;
   logic [PWM_W-1:0]        left_in;
   logic [PWM_W-1:0]        right_in;
   logic [PWM_W-1:0]        held_left_ff;
   logic [PWM_W-1:0]        held_right_ff;
   logic                    valid_ff;
   logic [PWM_W-1:0]        left_ff;
   logic [PWM_W-1:0]        right_ff;
   logic signed [ERR_W-1:0] err_ff;
   logic signed [PID_W-1:0] pid_ff;
   logic [LANE_MAX-1:0]     mask_ff;
   drive_case_type          case_ff;

   // turning speeds around the base
   assign base_ext  = $signed({{(SW-PWM_W){1'b0}}, base_speed});
   assign plus_pwm  = clamp_pwm(base_ext + SW'(stage.pid));
   assign minus_pwm = clamp_pwm(base_ext - SW'(stage.pid));

   // pick the drive case from the steering error
   always_comb begin
      if (stage.err == '0) begin
         case_in  = DRV_STOP;
         left_in  = '0;
         right_in = '0;
      end else if ((stage.err >= -STRAIGHT_LIMIT) && (stage.err <= STRAIGHT_LIMIT)) begin
         case_in  = DRV_STRAIGHT;
         left_in  = straight_left;
         right_in = straight_right;
      end else if (stage.err > HOLD_LIMIT) begin
         case_in  = DRV_RIGHT;
         left_in  = plus_pwm;
         right_in = minus_pwm;
      end else if (stage.err < -HOLD_LIMIT) begin
         case_in  = DRV_LEFT;
         left_in  = minus_pwm;
         right_in = plus_pwm;
      end else begin
         case_in  = DRV_HOLD;
         left_in  = held_left_ff;
         right_in = held_right_ff;
      end
   end

   // held speeds follow every transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         held_left_ff  <= '0;
         held_right_ff <= '0;
         valid_ff      <= 1'b0;
      end else if (adv) begin
         valid_ff <= stage.valid;
         if (stage.valid) begin
            held_left_ff  <= left_in;
            held_right_ff <= right_in;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (adv) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         err_ff   <= stage.err;
         pid_ff   <= stage.pid;
         mask_ff  <= stage.mask;
         case_ff  <= case_in;
      end
   end

   assign out_valid   = valid_ff;
   assign left_speed  = left_ff;
   assign right_speed = right_ff;
   assign steer_error = err_ff;
   assign pid_value   = pid_ff;
   assign black_mask  = mask_ff;
   assign drive_case  = case_ff;

endmodule

`default_nettype wire
